[hw/rtl/bpil_pkg.sv]
`timescale 1ns / 1ps

package bpil_pkg;

    localparam int BITMAP_WORD_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF       = 16;
    localparam int VECTOR_BITS_DEF      = 65536;

    localparam int IN_BITS    = 32;
    localparam int POS_BITS   = 11;
    localparam int POS_SPAN   = 1 << POS_BITS;
    localparam int HALF_BITS  = 16;
    localparam int PACK_BITS  = 2 * HALF_BITS;
    localparam int NUM_BITS   = 15;
    localparam int LSB_W      = $clog2(IN_BITS);
    localparam int S_TDATA_W  = ((IN_BITS + POS_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((PACK_BITS + NUM_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic             found;
        logic [LSB_W-1:0] pos;
        logic [IN_BITS-1:0] rest;
        logic             rest_empty;
    } lsb_t;

endpackage

[hw/rtl/bpil_lsb_find.sv]
`timescale 1ns / 1ps

module bpil_lsb_find (
    input  logic [bpil_pkg::IN_BITS-1:0] bits,
    output bpil_pkg::lsb_t               lsb
);

    logic [bpil_pkg::IN_BITS-1:0] cleared;

    always_comb begin
        lsb.pos = '0;
        for (int i = bpil_pkg::IN_BITS - 1; i >= 0; i--) begin
            if (bits[i]) begin
                lsb.pos = bpil_pkg::LSB_W'(i);
            end
        end
        // drop the lowest set bit
        cleared        = bits & (bits - bpil_pkg::IN_BITS'(1));
        lsb.found      = (bits != '0);
        lsb.rest       = cleared;
        lsb.rest_empty = (cleared == '0);
    end

endmodule

[hw/rtl/bitmap_to_packed_index_list.sv]
`timescale 1ns / 1ps
// output: the pair completed by a usable set bit of a bitmap word is registered in the
//   step that consumes that bit; a flush or end marker in the step that finds the word empty
// throughput: a new bitmap word is accepted only once every usable set bit of the previous
//   one is consumed; the single lowest-set-bit finder sets this, consuming one bit a cycle
//   while the output register is empty or being read
// reset (aresetn low, synchronous) clears the pending index, the word count and all valids

module bitmap_to_packed_index_list #(
    parameter int BITMAP_WORD_BITS = bpil_pkg::BITMAP_WORD_BITS_DEF,
    parameter int INDEX_BITS       = bpil_pkg::INDEX_BITS_DEF,
    parameter int VECTOR_BITS      = bpil_pkg::VECTOR_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bpil_pkg::S_TDATA_W-1:0]   s_tdata,  // bitmap_bits, word_position
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bpil_pkg::M_TDATA_W-1:0]   m_tdata,  // packed_word, word_number
    output logic                             m_tuser,  // word_valid
    output logic                             m_tlast
);

    localparam int BASE_RAW = $clog2(bpil_pkg::POS_SPAN * BITMAP_WORD_BITS);
    localparam int BASE_W   = (BASE_RAW > INDEX_BITS) ? BASE_RAW : INDEX_BITS;
    localparam int CMP_W    = (BASE_W > 17) ? BASE_W : 17;

    logic                            busy_reg, busy_next;
    logic [bpil_pkg::IN_BITS-1:0]    bits_reg, bits_next;
    logic [BASE_W-1:0]               base_reg, base_next;
    logic                            last_reg, last_next;
    logic                            any_reg, any_next;
    logic                            half_reg, half_next;
    logic [INDEX_BITS-1:0]           pend_reg, pend_next;
    logic [bpil_pkg::NUM_BITS-1:0]   cnt_reg, cnt_next;
    logic                            ovalid_reg, ovalid_next;
    logic [bpil_pkg::PACK_BITS-1:0]  opack_reg, opack_next;
    logic [bpil_pkg::NUM_BITS-1:0]   onum_reg, onum_next;
    logic                            ouser_reg, ouser_next;
    logic                            olast_reg, olast_next;

    bpil_pkg::lsb_t                  lsb;
    logic [bpil_pkg::POS_BITS-1:0]   pos_in;
    logic [BASE_W-1:0]               base_in;
    logic [CMP_W-1:0]                cmp_base;
    logic [CMP_W-1:0]                avail;
    logic [bpil_pkg::IN_BITS-1:0]    keep;
    logic [BASE_W-1:0]               idx_full;
    logic [INDEX_BITS-1:0]           idx;
    logic                            step;
    logic                            emit;

    bpil_lsb_find u_lsb (
        .bits (bits_reg),
        .lsb  (lsb)
    );

    assign s_tready = !busy_reg;
    assign pos_in   = s_tdata[bpil_pkg::IN_BITS +: bpil_pkg::POS_BITS];
    assign base_in  = BASE_W'(pos_in) * BASE_W'(BITMAP_WORD_BITS);
    assign cmp_base = CMP_W'(base_in);
    assign avail    = (cmp_base >= CMP_W'(VECTOR_BITS)) ? '0 : CMP_W'(VECTOR_BITS) - cmp_base;

    always_comb begin
        for (int i = 0; i < bpil_pkg::IN_BITS; i++) begin
            keep[i] = (CMP_W'(i) < avail) && (i < BITMAP_WORD_BITS);
        end
    end

    assign idx_full = base_reg + BASE_W'(lsb.pos);
    assign idx      = idx_full[INDEX_BITS-1:0];
    assign step     = busy_reg && (!ovalid_reg || m_tready);

    always_comb begin
        busy_next   = busy_reg;
        bits_next   = bits_reg;
        base_next   = base_reg;
        last_next   = last_reg;
        any_next    = any_reg;
        half_next   = half_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        opack_next  = opack_reg;
        onum_next   = onum_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;
        emit        = 1'b0;

        if (s_tvalid && s_tready) begin
            busy_next = 1'b1;
            bits_next = s_tdata[bpil_pkg::IN_BITS-1:0] & keep;
            base_next = base_in;
            last_next = s_tlast;
            any_next  = 1'b0;
        end else if (step) begin
            if (lsb.found) begin
                bits_next = lsb.rest;
                if (half_reg) begin
                    emit       = 1'b1;
                    opack_next = {bpil_pkg::HALF_BITS'(idx), bpil_pkg::HALF_BITS'(pend_reg)};
                    onum_next  = cnt_reg;
                    ouser_next = 1'b1;
                    olast_next = last_reg && lsb.rest_empty;
                    cnt_next   = cnt_reg + bpil_pkg::NUM_BITS'(1);
                    half_next  = 1'b0;
                    any_next   = 1'b1;
                end else begin
                    pend_next = idx;
                    half_next = 1'b1;
                end
            end else begin
                // word exhausted: flush or end marker on the final word
                busy_next = 1'b0;
                if (last_reg) begin
                    if (half_reg) begin
                        emit       = 1'b1;
                        opack_next = bpil_pkg::PACK_BITS'(pend_reg);
                        onum_next  = cnt_reg;
                        ouser_next = 1'b1;
                        olast_next = 1'b1;
                    end else if (!any_reg) begin
                        emit       = 1'b1;
                        opack_next = '0;
                        onum_next  = cnt_reg;
                        ouser_next = 1'b0;
                        olast_next = 1'b1;
                    end
                    half_next = 1'b0;
                    pend_next = '0;
                    cnt_next  = '0;
                end
            end
        end

        if (emit) begin
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end else begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            last_reg   <= 1'b0;
            any_reg    <= 1'b0;
            half_reg   <= 1'b0;
            pend_reg   <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            last_reg   <= last_next;
            any_reg    <= any_next;
            half_reg   <= half_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg  <= bits_next;
        base_reg  <= base_next;
        opack_reg <= opack_next;
        onum_reg  <= onum_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = bpil_pkg::M_TDATA_W'({onum_reg, opack_reg});
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

`ifndef SYNTHESIS
    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[bpil_pkg::PACK_BITS-1:0] == '0))
        else $error("end marker word malformed");

    a_list_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) && last_reg |-> (cnt_reg == '0) && !half_reg)
        else $error("list state not cleared after final word");

    a_no_pending_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && last_reg |-> !half_reg)
        else $error("pending index left after final word");
`endif

endmodule
